>>> hw/rtl/sdcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcb_pkg
// Types, command encodings and status codes of the SD card bring-up sequencer.
// ----------------------------------------------------------------------------
package sdcb_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);

    typedef enum logic [4:0] {
        PH_IDLE, PH_C0, PH_C8, PH_C55, PH_A41, PH_C2, PH_C3, PH_C9, PH_C7,
        PH_C16, PH_RCMD, PH_RRDY, PH_RDONE, PH_WCMD, PH_WRDY, PH_WDONE,
        PH_C13
    } t_phase;

    localparam logic [2:0] OP_PROBE    = 3'd0;
    localparam logic [2:0] OP_READ     = 3'd1;
    localparam logic [2:0] OP_WRITE    = 3'd2;
    localparam logic [2:0] OP_BARRIER  = 3'd3;
    localparam logic [2:0] OP_EVENT    = 3'd4;
    localparam logic [2:0] OP_DEADLINE = 3'd5;

    localparam logic [1:0] KIND_CMD    = 2'd0;
    localparam logic [1:0] KIND_RESET  = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;
    localparam logic [1:0] KIND_FINISH = 2'd3;

    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_TIMEOUT = 4'd1;
    localparam logic [3:0] ST_REMOVED = 4'd2;
    localparam logic [3:0] ST_ABSENT  = 4'd3;
    localparam logic [3:0] ST_UNSUP   = 4'd4;
    localparam logic [3:0] ST_CMD_CRC = 4'd5;
    localparam logic [3:0] ST_DAT_CRC = 4'd6;
    localparam logic [3:0] ST_FAILURE = 4'd7;
    localparam logic [3:0] ST_RANGE   = 4'd8;
    localparam logic [3:0] ST_NO_INIT = 4'd9;
    localparam logic [3:0] ST_RD_ONLY = 4'd10;
    localparam logic [3:0] ST_WR_UNK  = 4'd11;

    localparam logic [31:0] ALL_ONES  = 32'hffff_ffff;
    localparam logic [31:0] ERR_BITS  = 32'hffff_8000;
    localparam logic [31:0] ERR_TOUT  = 32'h0011_0000;
    localparam logic [31:0] ERR_CCRC  = 32'h0002_0000;
    localparam logic [31:0] ERR_DCRC  = 32'h0020_0000;
    localparam logic [31:0] I_CMD     = 32'h0000_0001;
    localparam logic [31:0] I_DATA    = 32'h0000_0002;
    localparam logic [31:0] I_WRDY    = 32'h0000_0010;
    localparam logic [31:0] I_RRDY    = 32'h0000_0020;

    localparam logic [31:0] RSP136 = 32'h0001_0000;
    localparam logic [31:0] RSP48  = 32'h0002_0000;
    localparam logic [31:0] RSP48B = 32'h0003_0000;
    localparam logic [31:0] CRCK   = 32'h0008_0000;
    localparam logic [31:0] IDXK   = 32'h0010_0000;
    localparam logic [31:0] DPRES  = 32'h0020_0000;
    localparam logic [31:0] DREAD  = 32'h0000_0010;

    localparam logic [31:0] CMD0  = 32'h0000_0000;
    localparam logic [31:0] CMD2  = (32'd2 << 24) | RSP136 | CRCK;
    localparam logic [31:0] CMD3  = (32'd3 << 24) | RSP48 | CRCK | IDXK;
    localparam logic [31:0] CMD7  = (32'd7 << 24) | RSP48B | CRCK | IDXK;
    localparam logic [31:0] CMD8  = (32'd8 << 24) | RSP48 | CRCK | IDXK;
    localparam logic [31:0] CMD9  = (32'd9 << 24) | RSP136 | CRCK;
    localparam logic [31:0] CMD13 = (32'd13 << 24) | RSP48 | CRCK | IDXK;
    localparam logic [31:0] CMD16 = (32'd16 << 24) | RSP48 | CRCK | IDXK;
    localparam logic [31:0] CMD17 = (32'd17 << 24) | RSP48 | CRCK | IDXK | DPRES | DREAD;
    localparam logic [31:0] CMD24 = (32'd24 << 24) | RSP48 | CRCK | IDXK | DPRES;
    localparam logic [31:0] ACMD41 = (32'd41 << 24) | RSP48;
    localparam logic [31:0] CMD55 = (32'd55 << 24) | RSP48 | CRCK | IDXK;

    localparam logic [31:0] CHECK_ARG  = 32'h0000_01aa;
    localparam logic [11:0] CHECK_PAT  = 12'h1aa;
    localparam logic [31:0] OCR_ARG    = 32'h40ff_8000;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [32:0] lba;
        logic        clocks_ok;
        logic        card_present;
        logic        write_enabled;
        logic [31:0] irq_flags;
        logic [31:0] resp_word0;
        logic [31:0] resp_word1;
        logic [31:0] resp_word2;
        logic [31:0] resp_word3;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] cmd_word;
        logic [31:0] cmd_arg;
        logic [31:0] ack_mask;
        logic [3:0]  status;
        logic [32:0] capacity;
        logic        wr_protect;
        logic        submitted;
        logic        last;
    } t_rsp;

    typedef struct packed {
        t_phase      phase;
        logic        card_ready;
        logic        high_capacity;
        logic [15:0] card_address;
        logic [32:0] sector_count;
        logic [31:0] last_irq;
        logic [31:0] pending_arg;
    } t_state;

    function automatic t_rsp f_cmd(logic [31:0] cw, logic [31:0] arg);
        t_rsp r;
        r = '0;
        r.kind     = KIND_CMD;
        r.cmd_word = cw;
        r.cmd_arg  = arg;
        r.ack_mask = ALL_ONES;
        r.last     = 1'b1;
        return r;
    endfunction

    function automatic t_rsp f_fin(logic [3:0] st, logic [31:0] ack, logic sub);
        t_rsp r;
        r = '0;
        r.kind      = KIND_FINISH;
        r.status    = st;
        r.ack_mask  = ack;
        r.submitted = sub;
        r.last      = 1'b1;
        return r;
    endfunction

endpackage

>>> hw/rtl/sdcb_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcb request and result channels
// Valid/ready channels that carry one request or one result item.
// ----------------------------------------------------------------------------
interface sdcb_req_if;
    logic           valid;
    logic           ready;
    sdcb_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sdcb_rsp_if;
    logic           valid;
    logic           ready;
    sdcb_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/sdcb_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcb_step
// Next-state and result logic for one request or host event.
// ----------------------------------------------------------------------------
module sdcb_step (
    input  sdcb_pkg::t_req   i_req,
    input  sdcb_pkg::t_state i_state,
    output sdcb_pkg::t_state o_state,
    output sdcb_pkg::t_rsp   o_rsp0,
    output sdcb_pkg::t_rsp   o_rsp1,
    output logic [1:0]       o_count
);

    logic [127:0] csd;
    logic [1:0]   csd_struct;
    logic [21:0]  c_size_v2;
    logic [11:0]  c_size_v1;
    logic [3:0]   read_bl;
    logic [2:0]   c_mult;
    logic [4:0]   v1_shift;
    logic [36:0]  v1_bytes;
    logic [32:0]  cap_v1;
    logic [32:0]  cap_v2;
    logic [31:0]  wanted;
    logic [31:0]  err_ack;
    logic [3:0]   err_st;
    logic         out_range;
    logic [31:0]  map_arg;
    logic [15:0]  rca;
    logic [32:0]  cap_new;

    // CSD image bit b sits at bit b-8 of the concatenated response words.
    assign csd        = {i_req.resp_word3, i_req.resp_word2, i_req.resp_word1,
                         i_req.resp_word0};
    assign csd_struct = csd[119:118];
    assign c_size_v2  = csd[61:40];
    assign c_size_v1  = csd[65:54];
    assign read_bl    = csd[75:72];
    assign c_mult     = csd[41:39];
    assign v1_shift   = 5'(c_mult) + 5'(read_bl) + 5'd2;
    assign v1_bytes   = 37'({1'b0, c_size_v1} + 13'd1) << v1_shift;
    assign cap_v1     = 33'(v1_bytes[36:sdcb_pkg::SECTOR_SHIFT]);
    assign cap_v2     = {23'({1'b0, c_size_v2} + 23'd1), 10'd0};

    assign out_range = (i_req.lba >= i_state.sector_count) ||
                       (i_state.high_capacity ? i_req.lba[32] : |i_req.lba[32:23]);
    assign map_arg   = i_state.high_capacity ? i_req.lba[31:0] :
                       {i_req.lba[22:0], 9'd0};
    assign rca       = i_req.resp_word0[31:16];

    always_comb begin
        case (i_state.phase)
            sdcb_pkg::PH_RRDY:  wanted = sdcb_pkg::I_RRDY;
            sdcb_pkg::PH_WRDY:  wanted = sdcb_pkg::I_WRDY;
            sdcb_pkg::PH_RDONE,
            sdcb_pkg::PH_WDONE: wanted = sdcb_pkg::I_DATA;
            default:            wanted = sdcb_pkg::I_CMD;
        endcase
    end

    always_comb begin
        o_state = i_state;
        o_rsp0  = '0;
        o_rsp1  = '0;
        o_count = 2'd0;
        err_st  = sdcb_pkg::ST_OK;
        err_ack = '0;
        cap_new = '0;
        if (i_state.phase == sdcb_pkg::PH_IDLE) begin
            case (i_req.opcode)
                sdcb_pkg::OP_PROBE: begin
                    o_count = 2'd1;
                    if (i_state.card_ready) begin
                        o_rsp0 = sdcb_pkg::f_fin(sdcb_pkg::ST_OK, '0, 1'b0);
                        o_rsp0.capacity   = i_state.sector_count;
                        o_rsp0.wr_protect = ~i_req.write_enabled;
                    end else if (!i_req.card_present) begin
                        o_rsp0 = sdcb_pkg::f_fin(sdcb_pkg::ST_ABSENT, '0, 1'b0);
                    end else if (!i_req.clocks_ok) begin
                        o_rsp0 = sdcb_pkg::f_fin(sdcb_pkg::ST_UNSUP, '0, 1'b0);
                    end else begin
                        o_rsp0 = '0;
                        o_rsp0.kind     = sdcb_pkg::KIND_RESET;
                        o_rsp0.ack_mask = sdcb_pkg::ALL_ONES;
                        o_rsp1 = sdcb_pkg::f_cmd(sdcb_pkg::CMD0, '0);
                        o_count = 2'd2;
                        o_state.phase = sdcb_pkg::PH_C0;
                        o_state.pending_arg = '0;
                    end
                end
                sdcb_pkg::OP_READ, sdcb_pkg::OP_WRITE: begin
                    o_count = 2'd1;
                    if (!i_state.card_ready) begin
                        o_rsp0 = sdcb_pkg::f_fin(sdcb_pkg::ST_NO_INIT, '0, 1'b0);
                    end else if (i_req.opcode == sdcb_pkg::OP_WRITE &&
                                 !i_req.write_enabled) begin
                        o_rsp0 = sdcb_pkg::f_fin(sdcb_pkg::ST_RD_ONLY, '0, 1'b0);
                    end else if (out_range) begin
                        o_rsp0 = sdcb_pkg::f_fin(sdcb_pkg::ST_RANGE, '0, 1'b0);
                    end else if (i_req.opcode == sdcb_pkg::OP_READ) begin
                        o_rsp0 = sdcb_pkg::f_cmd(sdcb_pkg::CMD17, map_arg);
                        o_state.phase = sdcb_pkg::PH_RCMD;
                        o_state.pending_arg = map_arg;
                    end else begin
                        o_rsp0 = sdcb_pkg::f_cmd(sdcb_pkg::CMD24, map_arg);
                        o_state.phase = sdcb_pkg::PH_WCMD;
                        o_state.pending_arg = map_arg;
                    end
                end
                sdcb_pkg::OP_BARRIER: begin
                    o_count = 2'd1;
                    if (!i_state.card_ready) begin
                        o_rsp0 = sdcb_pkg::f_fin(sdcb_pkg::ST_NO_INIT, '0, 1'b0);
                    end else begin
                        o_rsp0 = sdcb_pkg::f_cmd(sdcb_pkg::CMD13,
                                                 {i_state.card_address, 16'd0});
                        o_state.phase = sdcb_pkg::PH_C13;
                        o_state.pending_arg = {i_state.card_address, 16'd0};
                    end
                end
                default: ;
            endcase
        end else if (i_req.opcode == sdcb_pkg::OP_EVENT ||
                     i_req.opcode == sdcb_pkg::OP_DEADLINE) begin
            if (i_req.opcode == sdcb_pkg::OP_DEADLINE) begin
                err_st = sdcb_pkg::ST_TIMEOUT;
            end else if ((i_req.irq_flags & sdcb_pkg::ERR_BITS) != '0) begin
                o_state.last_irq = i_req.irq_flags;
                err_ack = i_req.irq_flags;
                if ((i_req.irq_flags & sdcb_pkg::ERR_TOUT) != '0) begin
                    err_st = sdcb_pkg::ST_TIMEOUT;
                end else if ((i_req.irq_flags & sdcb_pkg::ERR_CCRC) != '0) begin
                    err_st = sdcb_pkg::ST_CMD_CRC;
                end else if ((i_req.irq_flags & sdcb_pkg::ERR_DCRC) != '0) begin
                    err_st = sdcb_pkg::ST_DAT_CRC;
                end else begin
                    err_st = sdcb_pkg::ST_FAILURE;
                end
            end else if ((i_req.irq_flags & wanted) == '0 && !i_req.card_present) begin
                err_st = sdcb_pkg::ST_REMOVED;
            end

            if (err_st != sdcb_pkg::ST_OK) begin
                o_count = 2'd1;
                o_state.phase = sdcb_pkg::PH_IDLE;
                if (i_state.phase == sdcb_pkg::PH_C8) begin
                    o_rsp0 = sdcb_pkg::f_fin(sdcb_pkg::ST_UNSUP, err_ack, 1'b0);
                end else if (i_state.phase == sdcb_pkg::PH_WRDY ||
                             i_state.phase == sdcb_pkg::PH_WDONE) begin
                    o_rsp0 = sdcb_pkg::f_fin(sdcb_pkg::ST_WR_UNK, err_ack, 1'b1);
                end else begin
                    o_rsp0 = sdcb_pkg::f_fin(err_st, err_ack, 1'b0);
                end
            end else if ((i_req.irq_flags & wanted) != '0) begin
                o_count = 2'd1;
                case (i_state.phase)
                    sdcb_pkg::PH_C0: begin
                        o_rsp0 = sdcb_pkg::f_cmd(sdcb_pkg::CMD8, sdcb_pkg::CHECK_ARG);
                        o_state.phase = sdcb_pkg::PH_C8;
                        o_state.pending_arg = sdcb_pkg::CHECK_ARG;
                    end
                    sdcb_pkg::PH_C8: begin
                        if (i_req.resp_word0[11:0] != sdcb_pkg::CHECK_PAT) begin
                            o_rsp0 = sdcb_pkg::f_fin(sdcb_pkg::ST_UNSUP,
                                                     sdcb_pkg::I_CMD, 1'b0);
                            o_state.phase = sdcb_pkg::PH_IDLE;
                        end else begin
                            o_rsp0 = sdcb_pkg::f_cmd(sdcb_pkg::CMD55, '0);
                            o_state.phase = sdcb_pkg::PH_C55;
                            o_state.pending_arg = '0;
                        end
                    end
                    sdcb_pkg::PH_C55: begin
                        o_rsp0 = sdcb_pkg::f_cmd(sdcb_pkg::ACMD41, sdcb_pkg::OCR_ARG);
                        o_state.phase = sdcb_pkg::PH_A41;
                        o_state.pending_arg = sdcb_pkg::OCR_ARG;
                    end
                    sdcb_pkg::PH_A41: begin
                        o_state.pending_arg = '0;
                        if (!i_req.resp_word0[31]) begin
                            o_rsp0 = sdcb_pkg::f_cmd(sdcb_pkg::CMD55, '0);
                            o_state.phase = sdcb_pkg::PH_C55;
                        end else begin
                            o_state.high_capacity = i_req.resp_word0[30];
                            o_rsp0 = sdcb_pkg::f_cmd(sdcb_pkg::CMD2, '0);
                            o_state.phase = sdcb_pkg::PH_C2;
                        end
                    end
                    sdcb_pkg::PH_C2: begin
                        o_rsp0 = sdcb_pkg::f_cmd(sdcb_pkg::CMD3, '0);
                        o_state.phase = sdcb_pkg::PH_C3;
                        o_state.pending_arg = '0;
                    end
                    sdcb_pkg::PH_C3: begin
                        o_state.card_address = rca;
                        if (rca == '0) begin
                            o_rsp0 = sdcb_pkg::f_fin(sdcb_pkg::ST_UNSUP,
                                                     sdcb_pkg::I_CMD, 1'b0);
                            o_state.phase = sdcb_pkg::PH_IDLE;
                        end else begin
                            o_rsp0 = sdcb_pkg::f_cmd(sdcb_pkg::CMD9, {rca, 16'd0});
                            o_state.phase = sdcb_pkg::PH_C9;
                            o_state.pending_arg = {rca, 16'd0};
                        end
                    end
                    sdcb_pkg::PH_C9: begin
                        cap_new = (csd_struct == 2'd1) ? cap_v2 : cap_v1;
                        if (csd_struct == 2'd0 || csd_struct == 2'd1) begin
                            o_state.sector_count = cap_new;
                        end
                        if (csd_struct[1] || cap_new == '0) begin
                            o_rsp0 = sdcb_pkg::f_fin(sdcb_pkg::ST_UNSUP,
                                                     sdcb_pkg::I_CMD, 1'b0);
                            o_state.phase = sdcb_pkg::PH_IDLE;
                        end else begin
                            o_rsp0 = sdcb_pkg::f_cmd(sdcb_pkg::CMD7,
                                                     {i_state.card_address, 16'd0});
                            o_state.phase = sdcb_pkg::PH_C7;
                            o_state.pending_arg = {i_state.card_address, 16'd0};
                        end
                    end
                    sdcb_pkg::PH_C7, sdcb_pkg::PH_C16: begin
                        if (i_state.phase == sdcb_pkg::PH_C7 && !i_state.high_capacity) begin
                            o_rsp0 = sdcb_pkg::f_cmd(sdcb_pkg::CMD16,
                                                     32'(sdcb_pkg::SECTOR_BYTES));
                            o_state.phase = sdcb_pkg::PH_C16;
                            o_state.pending_arg = 32'(sdcb_pkg::SECTOR_BYTES);
                        end else begin
                            o_rsp0 = sdcb_pkg::f_fin(sdcb_pkg::ST_OK,
                                                     sdcb_pkg::I_CMD, 1'b0);
                            o_rsp0.capacity   = i_state.sector_count;
                            o_rsp0.wr_protect = ~i_req.write_enabled;
                            o_state.card_ready = 1'b1;
                            o_state.phase = sdcb_pkg::PH_IDLE;
                        end
                    end
                    sdcb_pkg::PH_RCMD: begin
                        o_count = 2'd0;
                        o_state.phase = sdcb_pkg::PH_RRDY;
                    end
                    sdcb_pkg::PH_WCMD: begin
                        o_count = 2'd0;
                        o_state.phase = sdcb_pkg::PH_WRDY;
                    end
                    sdcb_pkg::PH_RRDY: begin
                        o_rsp0.kind     = sdcb_pkg::KIND_DATA;
                        o_rsp0.ack_mask = sdcb_pkg::I_CMD | sdcb_pkg::I_RRDY;
                        o_rsp0.last     = 1'b1;
                        o_state.phase = sdcb_pkg::PH_RDONE;
                    end
                    sdcb_pkg::PH_WRDY: begin
                        o_rsp0.kind      = sdcb_pkg::KIND_DATA;
                        o_rsp0.ack_mask  = sdcb_pkg::I_CMD | sdcb_pkg::I_WRDY;
                        o_rsp0.submitted = 1'b1;
                        o_rsp0.last      = 1'b1;
                        o_state.phase = sdcb_pkg::PH_WDONE;
                    end
                    sdcb_pkg::PH_RDONE, sdcb_pkg::PH_WDONE: begin
                        o_rsp0 = sdcb_pkg::f_fin(sdcb_pkg::ST_OK, sdcb_pkg::I_DATA,
                                                 i_state.phase == sdcb_pkg::PH_WDONE);
                        o_state.phase = sdcb_pkg::PH_IDLE;
                    end
                    sdcb_pkg::PH_C13: begin
                        if (i_req.resp_word0[8] && i_req.resp_word0[12:9] == 4'd4) begin
                            o_rsp0 = sdcb_pkg::f_fin(sdcb_pkg::ST_OK,
                                                     sdcb_pkg::I_CMD, 1'b0);
                            o_state.phase = sdcb_pkg::PH_IDLE;
                        end else begin
                            o_rsp0 = sdcb_pkg::f_cmd(sdcb_pkg::CMD13,
                                                     {i_state.card_address, 16'd0});
                            o_state.pending_arg = {i_state.card_address, 16'd0};
                        end
                    end
                    default: begin
                        o_count = 2'd0;
                        o_state.phase = sdcb_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

>>> hw/rtl/sd_card_bringup_sequencer.sv
`timescale 1ns / 1ps
// Results are registered into the result queue when their request is accepted.
// Throughput: one request or host event per cycle while input ready is high;
// each produces zero, one or two results. A four-entry result queue decouples
// the sides; input ready drops while fewer than two entries are free.
// Reset (synchronous, active low) returns the sequencer to idle with no card known
// and empties the result queue.
// ----------------------------------------------------------------------------
// sd_card_bringup_sequencer
// SD card bring-up, single-sector read/write and transfer-state polling.
// ----------------------------------------------------------------------------
module sd_card_bringup_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdcb_req_if.sink   i_req,
    sdcb_rsp_if.source o_rsp
);

    sdcb_pkg::t_state r_state;
    sdcb_pkg::t_state n_state;
    sdcb_pkg::t_rsp   n_rsp0;
    sdcb_pkg::t_rsp   n_rsp1;
    logic [1:0]       n_count;
    sdcb_pkg::t_rsp   r_fifo [4];
    logic [1:0]       r_wr;
    logic [1:0]       r_rd;
    logic [2:0]       r_cnt;
    logic             req_acc;
    logic             rsp_acc;
    logic [1:0]       push;

    sdcb_step u_step (
        .i_req   (i_req.payload),
        .i_state (r_state),
        .o_state (n_state),
        .o_rsp0  (n_rsp0),
        .o_rsp1  (n_rsp1),
        .o_count (n_count)
    );

    assign i_req.ready   = (r_cnt <= 3'd2);
    assign req_acc       = i_req.valid && i_req.ready;
    assign rsp_acc       = o_rsp.valid && o_rsp.ready;
    assign push          = req_acc ? n_count : 2'd0;
    assign o_rsp.valid   = (r_cnt != 3'd0);
    assign o_rsp.payload = r_fifo[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_wr    <= '0;
            r_rd    <= '0;
            r_cnt   <= '0;
        end else begin
            if (req_acc) begin
                r_state <= n_state;
            end
            r_wr  <= r_wr + push;
            r_rd  <= r_rd + 2'(rsp_acc);
            r_cnt <= r_cnt + 3'(push) - 3'(rsp_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push != 2'd0) begin
            r_fifo[r_wr] <= n_rsp0;
        end
        if (push == 2'd2) begin
            r_fifo[r_wr + 2'd1] <= n_rsp1;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("result queue overflow");

    a_xfer_needs_card: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == sdcb_pkg::PH_RCMD || r_state.phase == sdcb_pkg::PH_WCMD ||
         r_state.phase == sdcb_pkg::PH_C13) |-> r_state.card_ready)
        else $error("transfer phase without an initialized card");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(o_rsp.payload))
        else $error("waiting result changed before it was taken");
`endif

endmodule
